FILE: hdl/tbc_pkg.sv
package tbc_pkg;

  localparam int unsigned NUM_LANES = 5;

  typedef enum logic {
    FUNC_PACK   = 1'b0,
    FUNC_UNPACK = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    TRIT_ZERO   = 2'b00,
    TRIT_PLUS   = 2'b01,
    TRIT_MINUS  = 2'b11,
    TRIT_MINUS2 = 2'b10
  } trit_code_t;

  typedef struct packed {
    logic [7:0]        term;
    logic signed [1:0] dec;
  } lane_res_t;

  localparam logic [7:0] DIV_MUL   [NUM_LANES] = '{8'd1, 8'd171, 8'd57, 8'd19, 8'd203};
  localparam logic [3:0] DIV_SHIFT [NUM_LANES] = '{4'd0, 4'd9, 4'd9, 4'd9, 4'd14};
  localparam logic [7:0] POW3      [NUM_LANES] = '{8'd1, 8'd3, 8'd9, 8'd27, 8'd81};

  function automatic logic [1:0] fold_mod3(input logic [7:0] x);
    logic [4:0] a;
    logic [3:0] b;
    logic [2:0] c;
    logic [1:0] d;
    a = {1'b0, x[7:4]} + {1'b0, x[3:0]};
    b = {1'b0, a[4:2]} + {2'b0, a[1:0]};
    c = {1'b0, b[3:2]} + {1'b0, b[1:0]};
    d = {1'b0, c[2]} + c[1:0];
    if (d == 2'd3) begin
      d = 2'd0;
    end
    return d;
  endfunction

endpackage

FILE: hdl/tbc_lane.sv
module tbc_lane #(
  parameter int unsigned K = 0
) (
  input  logic                   clk,
  input  logic                   en,
  input  tbc_pkg::func_t         func,
  input  logic [2:0]             count,
  input  logic [7:0]             in_byte,
  input  logic signed [1:0]      trit,
  output tbc_pkg::lane_res_t     res_r
);

  localparam logic [2:0] LANE_IDX = 3'(K);

  logic [15:0]        prod;
  logic [7:0]         quot;
  logic [1:0]         digit;
  logic               active;
  logic [7:0]         term;
  tbc_pkg::lane_res_t res_nxt;

  assign active = (count > LANE_IDX);
  assign prod   = {8'd0, in_byte} * {8'd0, tbc_pkg::DIV_MUL[K]};
  assign quot   = 8'(prod >> tbc_pkg::DIV_SHIFT[K]);
  assign digit  = tbc_pkg::fold_mod3(quot);

  always_comb begin
    case (tbc_pkg::trit_code_t'(trit))
      tbc_pkg::TRIT_ZERO:   term = tbc_pkg::POW3[K];
      tbc_pkg::TRIT_PLUS:   term = {tbc_pkg::POW3[K][6:0], 1'b0};
      tbc_pkg::TRIT_MINUS2: term = 8'd0 - tbc_pkg::POW3[K];
      tbc_pkg::TRIT_MINUS:  term = 8'd0;
      default:              term = 8'd0;
    endcase
  end

  always_comb begin
    res_nxt = '0;
    if (active) begin
      if (func == tbc_pkg::FUNC_PACK) begin
        res_nxt.term = term;
      end else begin
        res_nxt.dec = digit + 2'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: hdl/tbc_merge.sv
module tbc_merge (
  input  logic                 clk,
  input  logic                 en,
  input  tbc_pkg::lane_res_t   lanes [tbc_pkg::NUM_LANES],
  output logic [7:0]           out_byte_r,
  output logic signed [1:0]    dec_r [tbc_pkg::NUM_LANES]
);

  logic [7:0] sum_nxt;

  always_comb begin
    sum_nxt = 8'd0;
    for (int i = 0; i < tbc_pkg::NUM_LANES; i++) begin
      sum_nxt = sum_nxt + lanes[i].term;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_byte_r <= sum_nxt;
      for (int i = 0; i < tbc_pkg::NUM_LANES; i++) begin
        dec_r[i] <= lanes[i].dec;
      end
    end
  end

endmodule

FILE: hdl/ternary_base3_byte_codec_core.sv
// Ternary base-3 byte codec: five trits per byte.
// Input stream (in_*): in_tuser selects the function, 0 = pack five signed
// trits into one byte, 1 = unpack one byte into up to five trits. count gives
// how many trits the word carries; positions at or past count read as zero.
// Output stream (out_*): one word per input word, in order, carrying the
// packed byte (zero on unpack) and five decoded trits (zero on pack).
// Five lanes, one per trit position, each do a constant multiply-shift and a
// mod-3 fold or a weighted pack term; a merge stage sums the terms.
// Each word passes the lane register and then the merge register before out_tvalid.
// Throughput: one word per cycle while out_tready is high, through the two-register lane/merge pipeline.
// in_tready depends combinationally on out_tready; when the receiver stalls,
// the pipeline fills both stages and then drops in_tready, holding out_tdata.
// Reset (rst_n low, synchronous) empties the pipeline; out_tvalid goes low.
module ternary_base3_byte_codec_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // count[2:0], in_byte[10:3], trit_zero[12:11],
                                  // trit_one[14:13], trit_two[16:15],
                                  // trit_three[18:17], trit_four[20:19], zero pad
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // out_byte[7:0], dec_zero[9:8], dec_one[11:10],
                                  // dec_two[13:12], dec_three[15:14],
                                  // dec_four[17:16], zero pad
);

  logic                v1_r, v1_nxt;
  logic                v2_r, v2_nxt;
  logic                adv1;
  logic                adv2;
  logic                in_acc;
  tbc_pkg::lane_res_t  lane_res [tbc_pkg::NUM_LANES];
  logic [7:0]          out_byte;
  logic signed [1:0]   dec [tbc_pkg::NUM_LANES];

  assign adv2      = !v2_r || out_tready;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;
  assign in_acc    = in_tvalid && adv1;

  assign v1_nxt = adv1 ? in_acc : v1_r;
  assign v2_nxt = adv2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  for (genvar k = 0; k < tbc_pkg::NUM_LANES; k++) begin : g_lane
    tbc_lane #(.K(k)) u_lane (
      .clk     (clk),
      .en      (in_acc),
      .func    (tbc_pkg::func_t'(in_tuser)),
      .count   (in_tdata[2:0]),
      .in_byte (in_tdata[10:3]),
      .trit    (in_tdata[12 + 2*k -: 2]),
      .res_r   (lane_res[k])
    );
  end

  tbc_merge u_merge (
    .clk        (clk),
    .en         (v1_r && adv2),
    .lanes      (lane_res),
    .out_byte_r (out_byte),
    .dec_r      (dec)
  );

  assign out_tvalid = v2_r;
  assign out_tdata  = {6'd0, dec[4], dec[3], dec[2], dec[1], dec[0], out_byte};

endmodule

FILE: hdl/tbc_checker.sv
module tbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled while output side can move");

  a_one_function: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[7:0] != 8'd0) |-> (out_tdata[17:8] == 10'd0))
    else $error("packed byte and decoded trits both nonzero");

endmodule

bind ternary_base3_byte_codec_core tbc_checker u_tbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: bench/tb_ternary_base3_byte_codec_core.sv
module tb_ternary_base3_byte_codec_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 306;
  localparam int NUM_DIR = 22;

  typedef struct packed {
    tbc_pkg::func_t func;
    logic [2:0]     cnt;
    logic [7:0]     byte_in;
    logic [9:0]     trits;     // {trit_four, trit_three, trit_two, trit_one, trit_zero}
    logic           has_want;
    logic [23:0]    want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  logic        word_has_want = 1'b0;
  logic [23:0] word_want = '0;
  logic [23:0] pending_codec_words [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{tbc_pkg::FUNC_PACK,   3'd5, 8'h00, 10'b00_00_00_00_00, 1'b1, 24'h000079},
    '{tbc_pkg::FUNC_PACK,   3'd5, 8'hFF, 10'b01_01_01_01_01, 1'b1, 24'h0000F2},
    '{tbc_pkg::FUNC_PACK,   3'd5, 8'h00, 10'b11_11_11_11_11, 1'b1, 24'h000000},
    '{tbc_pkg::FUNC_PACK,   3'd5, 8'hAA, 10'b10_10_10_10_10, 1'b1, 24'h000087},
    '{tbc_pkg::FUNC_PACK,   3'd0, 8'hFF, 10'b01_01_01_01_01, 1'b1, 24'h000000},
    '{tbc_pkg::FUNC_PACK,   3'd7, 8'h55, 10'b01_01_01_01_01, 1'b1, 24'h0000F2},
    '{tbc_pkg::FUNC_PACK,   3'd6, 8'hFF, 10'b00_00_00_00_00, 1'b1, 24'h000079},
    '{tbc_pkg::FUNC_PACK,   3'd1, 8'h00, 10'b11_11_11_11_01, 1'b1, 24'h000002},
    '{tbc_pkg::FUNC_PACK,   3'd3, 8'h3C, 10'b01_11_01_00_11, 1'b0, 24'h000000},
    '{tbc_pkg::FUNC_PACK,   3'd2, 8'hC3, 10'b10_10_10_01_10, 1'b0, 24'h000000},
    '{tbc_pkg::FUNC_PACK,   3'd4, 8'h81, 10'b01_10_11_10_01, 1'b0, 24'h000000},
    '{tbc_pkg::FUNC_UNPACK, 3'd5, 8'h00, 10'b01_01_01_01_01, 1'b1, 24'h03FF00},
    '{tbc_pkg::FUNC_UNPACK, 3'd5, 8'hF2, 10'b00_00_00_00_00, 1'b1, 24'h015500},
    '{tbc_pkg::FUNC_UNPACK, 3'd5, 8'hFF, 10'b10_10_10_10_10, 1'b1, 24'h03C300},
    '{tbc_pkg::FUNC_UNPACK, 3'd0, 8'hFF, 10'b11_11_11_11_11, 1'b1, 24'h000000},
    '{tbc_pkg::FUNC_UNPACK, 3'd7, 8'hF2, 10'b01_01_01_01_01, 1'b1, 24'h015500},
    '{tbc_pkg::FUNC_UNPACK, 3'd6, 8'h00, 10'b00_00_00_00_00, 1'b1, 24'h03FF00},
    '{tbc_pkg::FUNC_UNPACK, 3'd1, 8'h00, 10'b11_11_11_11_11, 1'b1, 24'h000300},
    '{tbc_pkg::FUNC_UNPACK, 3'd5, 8'hF3, 10'b10_01_10_01_10, 1'b0, 24'h000000},
    '{tbc_pkg::FUNC_UNPACK, 3'd3, 8'h64, 10'b00_11_00_11_00, 1'b0, 24'h000000},
    '{tbc_pkg::FUNC_UNPACK, 3'd4, 8'h79, 10'b11_11_11_11_11, 1'b0, 24'h000000},
    '{tbc_pkg::FUNC_UNPACK, 3'd2, 8'hC8, 10'b01_00_10_11_01, 1'b0, 24'h000000}
  };

  ternary_base3_byte_codec_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic logic [23:0] predict_codec_word(input tbc_pkg::func_t f,
                                                     input logic [23:0] d);
    logic [2:0]          n;
    logic [7:0]          b;
    logic [7:0]          acc;
    logic [7:0]          dig;
    logic [7:0]          pw;
    logic [7:0]          q;
    logic [9:0]          decs;
    tbc_pkg::trit_code_t tc;
    n = d[2:0];
    if (n > 3'd5) begin
      n = 3'd5;
    end
    b = d[10:3];
    acc = '0;
    decs = '0;
    if (f == tbc_pkg::FUNC_PACK) begin
      for (int k = 4; k >= 0; k--) begin
        if (k < n) begin
          tc = tbc_pkg::trit_code_t'(d[11 + 2 * k +: 2]);
          case (tc)
            tbc_pkg::TRIT_ZERO:  dig = 8'd1;
            tbc_pkg::TRIT_PLUS:  dig = 8'd2;
            tbc_pkg::TRIT_MINUS: dig = 8'd0;
            default:             dig = 8'hFF;
          endcase
          acc = acc * 8'd3 + dig;
        end
      end
    end else begin
      pw = 8'd1;
      for (int k = 0; k < 5; k++) begin
        if (k < n) begin
          q = (b / pw) % 8'd3;
          decs[2 * k +: 2] = q[1:0] - 2'd1;
        end
        pw = pw * 8'd3;
      end
    end
    return {6'b0, decs, acc};
  endfunction

  function automatic logic [1:0] rand_trit();
    logic [1:0] t;
    if ($urandom_range(99) < 12) begin
      t = 2'($urandom_range(3));
    end else begin
      case ($urandom_range(2))
        0:       t = tbc_pkg::TRIT_MINUS;
        1:       t = tbc_pkg::TRIT_ZERO;
        default: t = tbc_pkg::TRIT_PLUS;
      endcase
    end
    return t;
  endfunction

  task automatic send_codec_word(input tbc_pkg::func_t f, input logic [23:0] d,
                                 input logic has_w, input logic [23:0] w);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser = f;
    in_tdata = d;
    word_has_want = has_w;
    word_want = w;
    in_tvalid = 1'b1;
    do begin
      @(posedge clk);
    end while (!(in_tvalid && in_tready));
    @(negedge clk);
  endtask

  task automatic send_random_words(input int n);
    logic [2:0] cnt;
    logic [9:0] trits;
    for (int i = 0; i < n; i++) begin
      cnt = ($urandom_range(99) < 70) ? 3'd5 : 3'($urandom_range(7));
      for (int k = 0; k < 5; k++) begin
        trits[2 * k +: 2] = rand_trit();
      end
      send_codec_word(tbc_pkg::func_t'($urandom_range(1)),
                      {3'b0, trits, 8'($urandom_range(255)), cnt},
                      1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    logic [23:0] want;
    if (rst_n && in_tvalid && in_tready) begin
      pending_codec_words.push_back(word_has_want ? word_want
                                    : predict_codec_word(tbc_pkg::func_t'(in_tuser),
                                                         in_tdata));
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_codec_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: out_tdata=%h", out_tdata);
        end
      end else begin
        want = pending_codec_words.pop_front();
        if (out_tdata[7:0] !== want[7:0] || out_tdata[9:8] !== want[9:8] ||
            out_tdata[11:10] !== want[11:10] || out_tdata[13:12] !== want[13:12] ||
            out_tdata[15:14] !== want[15:14] || out_tdata[17:16] !== want[17:16] ||
            out_tdata[23:18] !== want[23:18]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp byte=%h dec=%b pad=%b  act byte=%h dec=%b pad=%b",
                     want[7:0], want[17:8], want[23:18],
                     out_tdata[7:0], out_tdata[17:8], out_tdata[23:18]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** ternary_base3_byte_codec_core: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      send_codec_word(dir_rows[i].func,
                      {3'b0, dir_rows[i].trits, dir_rows[i].byte_in, dir_rows[i].cnt},
                      dir_rows[i].has_want, dir_rows[i].want);
    end

    send_random_words(PHASE_WORDS);

    snd_idle_pct = 68;
    send_random_words(PHASE_WORDS);

    snd_idle_pct = 0;
    rcv_stall_pct = 68;
    send_random_words(PHASE_WORDS);

    snd_idle_pct = 10;
    rcv_stall_pct = 10;
    send_random_words(PHASE_WORDS);

    // stall the output for a long stretch while input keeps coming
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_req = hold_req + 1;
    send_random_words(PHASE_WORDS);

    in_tvalid = 1'b0;
    while (pending_codec_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);

    if (mismatches == 0) begin
      $display("** ternary_base3_byte_codec_core: PASSED **");
    end else begin
      $display("** ternary_base3_byte_codec_core: FAILED **");
    end
    $finish;
  end

endmodule
